// ===== rtl/assert_macros.svh =====
// Assertion macros used by the search core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, idle during reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/scds_pkg.sv =====
// Shared constants, status codes and pipeline word types of the divider search.
// No dependencies.
package scds_pkg;

  localparam int CLK_W        = 27;
  localparam int RATE_W       = 25;
  localparam int Q_W          = 27;
  localparam int D_W          = 16;
  localparam int T_W          = 9;
  localparam int P_W          = 8;
  localparam int SCR_W        = 8;
  localparam int MAX_PRESCALE = 254;
  localparam int NUM_PRE      = MAX_PRESCALE / 2;
  localparam int RECIP_SH     = 24;
  localparam int M_W          = 24;
  localparam int A1_W         = Q_W + 1;

  localparam logic [CLK_W-1:0]  SYS_CLK_RESET   = 27'd16000000;
  localparam logic [RATE_W-1:0] MASTER_MAX_RATE = 25'd25000000;
  localparam logic [RATE_W-1:0] SLAVE_MAX_RATE  = 25'd6000000;
  localparam logic [3:0]        SLAVE_RATIO     = 4'd12;
  // largest t, so that scr = t - 1 stays within 0..255
  localparam logic [D_W-1:0]    T_MAX           = 16'd256;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_MASTER_HIGH = 2'd1,
    ST_SLAVE_HIGH  = 2'd2,
    ST_NO_FIT      = 2'd3
  } status_t;

  // sideband carried through the dividers
  typedef struct packed {
    status_t          st;
    logic [Q_W-1:0]   q;
    logic             dok;
  } side_t;

  typedef struct packed {
    logic              vld;
    side_t             side;
    logic [RATE_W-1:0] dvs;
    logic [RATE_W-1:0] rem;
    logic [Q_W-1:0]    quo;
  } div_t;

  // word of the largest-divider chain
  typedef struct packed {
    logic           vld;
    status_t        st;
    logic [Q_W-1:0] q;
    logic [D_W-1:0] dmax;
    logic           dok;
  } p1_t;

  // word of the prescaler pick chain
  typedef struct packed {
    logic             vld;
    status_t          st;
    logic [Q_W-1:0]   q;
    logic             dok;
    logic [A1_W-1:0]  a1;
    logic [P_W-1:0]   bp;
    logic [SCR_W-1:0] bs;
  } p2_t;

endpackage

// ===== rtl/scds_div.sv =====
// Pipelined restoring divider: system clock over a word's divisor, one quotient bit per stage.
// Depends on scds_pkg.
module scds_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [scds_pkg::CLK_W-1:0] num,
  input  scds_pkg::div_t             d_in,
  output scds_pkg::div_t             d_out
);
  import scds_pkg::*;

  div_t stg_r [0:Q_W-1];
  div_t cur   [0:Q_W-1];

  for (genvar i = 0; i < Q_W; i++) begin : g_stg
    logic [RATE_W:0] trial;
    logic [RATE_W:0] diff;
    logic            take;
    div_t            stg_nxt;

    if (i == 0) begin : g_first
      assign cur[i] = d_in;
    end else begin : g_rest
      assign cur[i] = stg_r[i-1];
    end

    assign trial = {cur[i].rem, num[Q_W-1-i]};
    assign diff  = trial - {1'b0, cur[i].dvs};
    assign take  = (trial >= {1'b0, cur[i].dvs});

    always_comb begin
      stg_nxt     = cur[i];
      stg_nxt.rem = take ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      stg_nxt.quo = {cur[i].quo[Q_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[i].vld <= 1'b0;
      end else if (en) begin
        stg_r[i] <= stg_nxt;
      end
    end
  end

  assign d_out = stg_r[Q_W-1];

endmodule

// ===== rtl/scds_max_cell.sv =====
// One prescaler cell of the largest-divider chain: t = q / p, keep the largest p * t.
// Depends on scds_pkg.
module scds_max_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [scds_pkg::P_W-1:0]   p,
  input  logic [scds_pkg::M_W-1:0]   m,
  input  scds_pkg::p1_t              c_in,
  output scds_pkg::p1_t              c_out
);
  import scds_pkg::*;

  logic [D_W+M_W-1:0] prod;
  logic [D_W-1:0]     tq;
  logic               ok;
  p1_t                a_r;
  logic [T_W-1:0]     t_a_r;
  logic               ok_a_r;
  logic [P_W+T_W-1:0] dw;
  p1_t                b_nxt;
  p1_t                b_r;

  // exact for a 16-bit quotient input and the 2^24 reciprocal
  assign prod = (D_W+M_W)'(c_in.q[D_W-1:0]) * (D_W+M_W)'(m);
  assign tq   = prod[RECIP_SH +: D_W];
  assign ok   = !(|c_in.q[Q_W-1:D_W]) && (tq != '0) && (tq <= T_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
    end else if (en) begin
      a_r    <= c_in;
      t_a_r  <= tq[T_W-1:0];
      ok_a_r <= ok;
    end
  end

  assign dw = (P_W+T_W)'(p) * (P_W+T_W)'(t_a_r);

  always_comb begin
    b_nxt = a_r;
    if (ok_a_r && (!a_r.dok || dw[D_W-1:0] >= a_r.dmax)) begin
      b_nxt.dmax = dw[D_W-1:0];
      b_nxt.dok  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.vld <= 1'b0;
    end else if (en) begin
      b_r <= b_nxt;
    end
  end

  assign c_out = b_r;

endmodule

// ===== rtl/scds_pick_cell.sv =====
// One prescaler cell of the pick chain: take p when its rate equals the best rate.
// Depends on scds_pkg.
module scds_pick_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [scds_pkg::CLK_W-1:0] sys_clk,
  input  logic [scds_pkg::P_W-1:0]   p,
  input  logic [scds_pkg::M_W-1:0]   m,
  input  scds_pkg::p2_t              c_in,
  output scds_pkg::p2_t              c_out
);
  import scds_pkg::*;

  logic [D_W+M_W-1:0]  prod;
  logic [D_W-1:0]      tq;
  logic                ok;
  p2_t                 a_r;
  logic [T_W-1:0]      t_a_r;
  logic                ok_a_r;
  logic [P_W+T_W-1:0]  dw;
  p2_t                 b_r;
  logic [T_W-1:0]      t_b_r;
  logic [D_W-1:0]      d_b_r;
  logic                ok_b_r;
  logic [D_W+A1_W-1:0] dprod;
  logic                hit;
  logic [T_W-1:0]      scr;
  p2_t                 c_nxt;
  p2_t                 c_r;

  assign prod = (D_W+M_W)'(c_in.q[D_W-1:0]) * (D_W+M_W)'(m);
  assign tq   = prod[RECIP_SH +: D_W];
  assign ok   = !(|c_in.q[Q_W-1:D_W]) && (tq != '0) && (tq <= T_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
    end else if (en) begin
      a_r    <= c_in;
      t_a_r  <= tq[T_W-1:0];
      ok_a_r <= ok;
    end
  end

  assign dw = (P_W+T_W)'(p) * (P_W+T_W)'(t_a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.vld <= 1'b0;
    end else if (en) begin
      b_r    <= a_r;
      t_b_r  <= t_a_r;
      d_b_r  <= dw[D_W-1:0];
      ok_b_r <= ok_a_r;
    end
  end

  // clk / d equals the best rate exactly when d * (best + 1) exceeds clk
  assign dprod = (D_W+A1_W)'(d_b_r) * (D_W+A1_W)'(b_r.a1);
  assign hit   = ok_b_r && (dprod > (D_W+A1_W)'(sys_clk));
  assign scr   = t_b_r - 1'b1;

  always_comb begin
    c_nxt = b_r;
    if (hit) begin
      c_nxt.bp = p;
      c_nxt.bs = scr[SCR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

// ===== rtl/spi_clock_divider_search_core.sv =====
// Serial clock prescaler and scr search. A word passes a 27-stage divider, 127 cells
// of 2 stages, a 27-stage divider, 127 cells of 3 stages and the output register;
// one word per cycle while the buffer is empty, the cell pipeline advancing as one.
// A two-entry output buffer takes the last word while out_ready is low.
// Synchronous active-low reset empties the pipeline and loads a 16 MHz system clock.
`include "assert_macros.svh"

module spi_clock_divider_search_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [scds_pkg::CLK_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scds_pkg::RATE_W-1:0] in_bit_rate_hz,
  input  logic                        in_is_slave,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scds_pkg::P_W-1:0]    out_prescale_divisor,
  output logic [scds_pkg::SCR_W-1:0]  out_serial_clock_rate,
  output logic [1:0]                  out_status
);
  import scds_pkg::*;

  logic [CLK_W-1:0] sys_clk_r;
  logic             en;
  logic [CLK_W-1:0] rate2;
  logic [RATE_W+3:0] rate12;
  status_t          st_in;
  div_t             d1_in;
  div_t             d1_out;
  div_t             d2_in;
  div_t             d2_out;
  p1_t              p1 [0:NUM_PRE];
  p2_t              p2 [0:NUM_PRE];
  status_t          fin_st;
  logic [P_W-1:0]   fin_p;
  logic [SCR_W-1:0] fin_s;
  logic             push;
  logic             out_vld_r;
  logic [P_W-1:0]   out_p_r;
  logic [SCR_W-1:0] out_s_r;
  status_t          out_st_r;
  logic             skid_vld_r;
  logic [P_W-1:0]   skid_p_r;
  logic [SCR_W-1:0] skid_s_r;
  status_t          skid_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_clk_r <= SYS_CLK_RESET;
    end else if (cfg_wr_en) begin
      sys_clk_r <= cfg_wr_data;
    end
  end

  // stall the whole pipeline only while the buffer entry is taken
  assign en       = !skid_vld_r;
  assign in_ready = en;

  assign rate2  = {1'b0, in_bit_rate_hz, 1'b0};
  assign rate12 = (RATE_W+4)'(in_bit_rate_hz) * (RATE_W+4)'(SLAVE_RATIO);

  always_comb begin
    st_in = ST_OK;
    if (!in_is_slave) begin
      if (rate2 > sys_clk_r || in_bit_rate_hz > MASTER_MAX_RATE) begin
        st_in = ST_MASTER_HIGH;
      end
    end else begin
      if (rate12 > (RATE_W+4)'(sys_clk_r) || in_bit_rate_hz > SLAVE_MAX_RATE) begin
        st_in = ST_SLAVE_HIGH;
      end
    end
    if (st_in == ST_OK && in_bit_rate_hz == '0) begin
      st_in = ST_NO_FIT;
    end
  end

  always_comb begin
    d1_in          = '0;
    d1_in.vld      = in_valid;
    d1_in.side.st  = st_in;
    d1_in.dvs      = in_bit_rate_hz;
  end

  scds_div u_div_q (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .num   (sys_clk_r),
    .d_in  (d1_in),
    .d_out (d1_out)
  );

  always_comb begin
    p1[0]      = '0;
    p1[0].vld  = d1_out.vld;
    p1[0].st   = d1_out.side.st;
    p1[0].q    = d1_out.quo;
  end

  for (genvar i = 0; i < NUM_PRE; i++) begin : g_max
    localparam int P = 2 * (i + 1);
    localparam int M = ((1 << RECIP_SH) + P - 1) / P;
    scds_max_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .p     (P_W'(P)),
      .m     (M_W'(M)),
      .c_in  (p1[i]),
      .c_out (p1[i+1])
    );
  end

  always_comb begin
    d2_in          = '0;
    d2_in.vld      = p1[NUM_PRE].vld;
    d2_in.side.st  = p1[NUM_PRE].st;
    d2_in.side.q   = p1[NUM_PRE].q;
    d2_in.side.dok = p1[NUM_PRE].dok;
    d2_in.dvs      = RATE_W'(p1[NUM_PRE].dmax);
  end

  // best achievable rate = clk / largest divider
  scds_div u_div_best (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .num   (sys_clk_r),
    .d_in  (d2_in),
    .d_out (d2_out)
  );

  always_comb begin
    p2[0]      = '0;
    p2[0].vld  = d2_out.vld;
    p2[0].st   = d2_out.side.st;
    p2[0].q    = d2_out.side.q;
    p2[0].dok  = d2_out.side.dok;
    p2[0].a1   = A1_W'(d2_out.quo) + 1'b1;
  end

  for (genvar i = 0; i < NUM_PRE; i++) begin : g_pick
    localparam int P = 2 * (i + 1);
    localparam int M = ((1 << RECIP_SH) + P - 1) / P;
    scds_pick_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .sys_clk (sys_clk_r),
      .p       (P_W'(P)),
      .m       (M_W'(M)),
      .c_in    (p2[i]),
      .c_out   (p2[i+1])
    );
  end

  always_comb begin
    fin_st = p2[NUM_PRE].st;
    if (fin_st == ST_OK && !p2[NUM_PRE].dok) begin
      fin_st = ST_NO_FIT;
    end
    fin_p = (fin_st == ST_OK) ? p2[NUM_PRE].bp : '0;
    fin_s = (fin_st == ST_OK) ? p2[NUM_PRE].bs : '0;
  end

  assign push = en && p2[NUM_PRE].vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_ready) begin
      // hold the output word, park a new one in the buffer
      if (push) begin
        skid_vld_r <= 1'b1;
        skid_p_r   <= fin_p;
        skid_s_r   <= fin_s;
        skid_st_r  <= fin_st;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      out_p_r    <= skid_p_r;
      out_s_r    <= skid_s_r;
      out_st_r   <= skid_st_r;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= push;
      out_p_r   <= fin_p;
      out_s_r   <= fin_s;
      out_st_r  <= fin_st;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_prescale_divisor  = out_p_r;
  assign out_serial_clock_rate = out_s_r;
  assign out_status            = out_st_r;

  `ASSERT_IMP(a_skid_needs_out, skid_vld_r, out_vld_r)
  `ASSERT_IMP(a_fail_zero, out_vld_r && out_st_r != ST_OK, out_p_r == '0 && out_s_r == '0)
  `ASSERT_IMP(a_ok_prescale, out_vld_r && out_st_r == ST_OK, out_p_r != '0 && !out_p_r[0])
  `ASSERT_NXT(a_skid_holds, skid_vld_r && !out_ready, skid_vld_r && $stable(skid_p_r))

endmodule
